FILE: hdl/fir_pkg.sv
// Package for the firmware image receiver: item and result types, phase and
// error codes, register indexes and reset values. No dependencies.
package fir_pkg;

  localparam int unsigned HdrBytes = 4;
  localparam logic [31:0] MaxSizeReset = 32'd262144;
  localparam logic [15:0] TimeoutReset = 16'd5000;
  localparam logic [2:0] HdrCountSat = 3'd5;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PROG  = 2'd1,
    PH_READY = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_INDEX = 2'd1,
    ERR_SIZE  = 2'd2,
    ERR_LARGE = 2'd3
  } err_t;

  typedef enum logic {
    CFG_MAX_SIZE = 1'b0,
    CFG_TIMEOUT  = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    MODE_BYTE = 1'b0,
    MODE_TICK = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] packet_index;
    logic [7:0] data_byte;
    logic       first_of_packet;
    logic       last_of_packet;
  } item_t;

  typedef struct packed {
    logic        write_strobe;
    logic [7:0]  write_byte;
    logic        open_strobe;
    logic [31:0] open_size;
    logic        close_strobe;
    logic        clear_strobe;
    logic        packet_done;
    err_t        error_code;
    phase_t      phase_now;
    logic        still_active;
  } result_t;

endpackage

FILE: hdl/fir_in_stage.sv
// Input register of the firmware image receiver.
// Depends on fir_pkg.
module fir_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  fir_pkg::item_t in_item,
  input  logic           advance,   // downstream takes the held item this cycle
  output logic           item_valid,
  output fir_pkg::item_t item
);
  import fir_pkg::*;

  logic  valid_r;
  item_t item_r;

  assign in_tready  = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= in_item;
    end
  end

endmodule

FILE: hdl/fir_core.sv
// Transfer state and per-item decision logic of the firmware image receiver:
// header parse, index check, byte countdown and tick timeout. Depends on fir_pkg.
module fir_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  fir_pkg::cfg_idx_t cfg_index,
  input  logic [31:0]      cfg_wdata,
  input  logic             go,        // held item is processed this cycle
  input  fir_pkg::item_t   item,
  output fir_pkg::result_t res
);
  import fir_pkg::*;

  logic [31:0] max_size_r;
  logic [15:0] timeout_r;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  exp_idx_r, exp_idx_nxt;
  logic [31:0] bytes_left_r, bytes_left_nxt;
  logic [31:0] hdr_shift_r, hdr_shift_nxt;
  logic [2:0]  hdr_count_r, hdr_count_nxt;
  err_t        fault_r, fault_nxt;
  logic [15:0] idle_ticks_r, idle_ticks_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_size_r <= MaxSizeReset;
      timeout_r  <= TimeoutReset;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_SIZE: max_size_r <= cfg_wdata;
        CFG_TIMEOUT:  timeout_r  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [15:0] ticks;
    logic [31:0] hs_b;
    logic [2:0]  hc_b;
    err_t        pf_b;

    res            = '0;
    phase_nxt      = phase_r;
    exp_idx_nxt    = exp_idx_r;
    bytes_left_nxt = bytes_left_r;
    hdr_shift_nxt  = hdr_shift_r;
    hdr_count_nxt  = hdr_count_r;
    fault_nxt      = fault_r;
    idle_ticks_nxt = idle_ticks_r;
    ticks          = idle_ticks_r;

    // first mark restarts the per-packet accumulators
    hs_b = item.first_of_packet ? 32'd0 : hdr_shift_r;
    hc_b = item.first_of_packet ? 3'd0 : hdr_count_r;
    pf_b = item.first_of_packet ? ERR_NONE : fault_r;

    if (item.mode == MODE_TICK) begin
      if (phase_r == PH_PROG) begin
        ticks = (idle_ticks_r != 16'hFFFF) ? idle_ticks_r + 16'd1 : idle_ticks_r;
        idle_ticks_nxt = ticks;
        if (ticks >= timeout_r) begin
          res.close_strobe = 1'b1;
          res.clear_strobe = 1'b1;
          phase_nxt        = PH_IDLE;
          hdr_shift_nxt    = '0;
          hdr_count_nxt    = '0;
          fault_nxt        = ERR_NONE;
        end else begin
          res.still_active = 1'b1;
        end
      end
    end else begin
      idle_ticks_nxt = '0;
      hdr_shift_nxt  = hs_b;
      hdr_count_nxt  = hc_b;
      fault_nxt      = pf_b;
      case (phase_r)
        PH_IDLE: begin
          if (item.packet_index != 8'd0) fault_nxt = ERR_INDEX;
          hdr_shift_nxt = {hs_b[23:0], item.data_byte};
          hdr_count_nxt = (hc_b < HdrCountSat) ? hc_b + 3'd1 : hc_b;
          if (item.last_of_packet) begin
            res.packet_done = 1'b1;
            if (fault_nxt == ERR_INDEX) begin
              res.error_code = ERR_INDEX;
            end else if (hdr_count_nxt != 3'(HdrBytes)) begin
              res.error_code = ERR_SIZE;
            end else if (hdr_shift_nxt > max_size_r) begin
              res.error_code = ERR_LARGE;
            end else begin
              res.open_strobe = 1'b1;
              res.open_size   = hdr_shift_nxt;
              bytes_left_nxt  = hdr_shift_nxt;
              exp_idx_nxt     = 8'd1;
              phase_nxt       = PH_PROG;
            end
          end
        end
        PH_PROG: begin
          if (item.packet_index != exp_idx_r) fault_nxt = ERR_INDEX;
          if (fault_nxt == ERR_NONE) begin
            if (bytes_left_r != 32'd0) begin
              res.write_strobe = 1'b1;
              res.write_byte   = item.data_byte;
              bytes_left_nxt   = bytes_left_r - 32'd1;
            end else begin
              fault_nxt = ERR_SIZE;
            end
          end
          if (item.last_of_packet) begin
            res.packet_done = 1'b1;
            if (fault_nxt != ERR_NONE) begin
              res.error_code   = fault_nxt;
              res.close_strobe = 1'b1;
              res.clear_strobe = 1'b1;
              phase_nxt        = PH_IDLE;
            end else if (bytes_left_nxt != 32'd0) begin
              exp_idx_nxt = item.packet_index + 8'd1;
            end else begin
              res.close_strobe = 1'b1;
              phase_nxt        = PH_READY;
            end
          end
        end
        default: begin
          // ready: the packet's last byte drops the finished image
          if (item.last_of_packet) begin
            res.packet_done  = 1'b1;
            res.error_code   = ERR_INDEX;
            res.clear_strobe = 1'b1;
            phase_nxt        = PH_IDLE;
          end
        end
      endcase
      if (item.last_of_packet) begin
        hdr_shift_nxt = '0;
        hdr_count_nxt = '0;
        fault_nxt     = ERR_NONE;
      end
    end
    res.phase_now = phase_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      exp_idx_r    <= '0;
      bytes_left_r <= '0;
      hdr_shift_r  <= '0;
      hdr_count_r  <= '0;
      fault_r      <= ERR_NONE;
      idle_ticks_r <= '0;
    end else if (go) begin
      phase_r      <= phase_nxt;
      exp_idx_r    <= exp_idx_nxt;
      bytes_left_r <= bytes_left_nxt;
      hdr_shift_r  <= hdr_shift_nxt;
      hdr_count_r  <= hdr_count_nxt;
      fault_r      <= fault_nxt;
      idle_ticks_r <= idle_ticks_nxt;
    end
  end

  a_open_enters_prog: assert property (@(posedge clk) disable iff (!rst_n)
    go && res.open_strobe |=> phase_r == PH_PROG && exp_idx_r == 8'd1)
    else $error("open did not start a transfer");

  a_write_counts_down: assert property (@(posedge clk) disable iff (!rst_n)
    go && res.write_strobe |=> bytes_left_r == $past(bytes_left_r) - 32'd1)
    else $error("write did not consume one byte of the size");

  a_write_only_in_prog: assert property (@(posedge clk) disable iff (!rst_n)
    go && res.write_strobe |-> phase_r == PH_PROG && item.mode == MODE_BYTE)
    else $error("write outside a transfer");

  a_hdr_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_count_r <= HdrCountSat)
    else $error("header count past saturation");

endmodule

FILE: hdl/fir_out_stage.sv
// Result register of the firmware image receiver, with the output handshake.
// Depends on fir_pkg.
module fir_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_valid,
  input  fir_pkg::result_t res,
  output logic             advance,
  output logic             out_tvalid,
  input  logic             out_tready,
  output fir_pkg::result_t out_res
);
  import fir_pkg::*;

  logic    valid_r;
  result_t res_r;

  // result slot frees up when empty or when it is taken this cycle
  assign advance    = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_res    = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid) begin
      res_r <= res;
    end
  end

endmodule

FILE: hdl/firmware_image_receiver_top.sv
// Firmware image receiver. Takes one item per cycle (a packet byte or a tick)
// while out_tready holds, and returns exactly one result item per input item,
// held in the input register, then the result register; fir_core updates the
// transfer state for each item as it is processed, so no item waits on another.
// Depends on fir_pkg, fir_in_stage, fir_core, fir_out_stage.
module firmware_image_receiver_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,   // 0 max_image_size, 1 timeout_ticks
  input  logic [31:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // packet_index [7:0], data_byte [15:8]
  input  logic [1:0]  in_tuser,    // mode [0], first_of_packet [1]
  input  logic        in_tlast,    // last_of_packet
  output logic        out_tvalid,
  input  logic        out_tready,
  // write_strobe [0], write_byte [8:1], open_strobe [9], open_size [41:10],
  // close_strobe [42], clear_strobe [43], packet_done [44], error_code [46:45],
  // phase_now [48:47], still_active [49], zero [55:50]
  output logic [55:0] out_tdata
);
  import fir_pkg::*;

  item_t   in_item, item;
  result_t res, out_res;
  logic    item_valid, advance, go;

  assign in_item.mode            = mode_t'(in_tuser[0]);
  assign in_item.packet_index    = in_tdata[7:0];
  assign in_item.data_byte       = in_tdata[15:8];
  assign in_item.first_of_packet = in_tuser[1];
  assign in_item.last_of_packet  = in_tlast;

  assign go = item_valid && advance;

  fir_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  fir_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_idx_t'(cfg_index)),
    .cfg_wdata (cfg_wdata),
    .go        (go),
    .item      (item),
    .res       (res)
  );

  fir_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .res        (res),
    .advance    (advance),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = {6'd0,
                      out_res.still_active,
                      out_res.phase_now,
                      out_res.error_code,
                      out_res.packet_done,
                      out_res.clear_strobe,
                      out_res.close_strobe,
                      out_res.open_size,
                      out_res.open_strobe,
                      out_res.write_byte,
                      out_res.write_strobe};

endmodule
